FILE: hdl/mcma_pkg.sv
// shared types and constants of the min-cost manhattan assignment block
`timescale 1ns / 1ps

package mcma_pkg;

  // width of a dp table entry: saturated cost plus an infinity code
  localparam int COST_W = 12;
  // width of the reported total distance
  localparam int DIST_OUT_W = 11;

  typedef logic [COST_W-1:0] cost_t;

  // saturation ceiling for partial sums and the unreachable marker
  localparam cost_t COST_CAP = cost_t'(2047);
  localparam cost_t COST_INF = cost_t'(4095);

  // status returned by the dp engine to the controller
  typedef struct packed {
    logic  done;
    cost_t best;
  } dp_status_t;

endpackage

FILE: hdl/min_cost_manhattan_assignment_top.sv
// top level: point loading, feasibility check and result register
`timescale 1ns / 1ps

// Loads target and source grid points one per transaction and, on the
// transaction marked last, finds the least total Manhattan distance when each
// target in load order takes a distinct source. Load transactions are taken one
// per cycle while the block is loading. The last one stalls the input for the
// computation and until the output register is free. With at least one target
// and no more targets than sources, the computation clears the dp table and
// then sweeps it, one table read-modify-write per cycle through the single dp
// memory. An empty target list or more targets than sources gives a result
// without running the sweep. The result waits in an output register, so
// loading of the next list goes on while it is not yet taken. Points beyond
// MAX_POINTS per list are dropped and flagged by overflow.
module min_cost_manhattan_assignment_top #(
  parameter int MAX_POINTS = 15,
  parameter int COORD_BITS = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                is_source,
  input  logic [COORD_BITS-1:0]               row,
  input  logic [COORD_BITS-1:0]               col,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcma_pkg::DIST_OUT_W-1:0]     total_distance,
  output logic                                infeasible,
  output logic                                overflow
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_CHECK,
    S_RUN,
    S_EMIT
  } state_t;

  state_t                            state;
  logic                              accept;
  logic                              drop;
  logic                              emit_ok;
  logic                              clear_lists;
  logic                              start;
  logic                              overflow_seen;
  logic [mcma_pkg::DIST_OUT_W-1:0]   res_dist;
  logic                              res_inf;
  logic [CNT_W-1:0]                  target_count;
  logic [CNT_W-1:0]                  source_count;
  mcma_pkg::dp_status_t              status;

  // handshake and list-full detection
  assign in_ready    = (state == S_LOAD);
  assign accept      = in_valid && in_ready;
  assign drop        = is_source ? (source_count == CNT_W'(MAX_POINTS))
                                 : (target_count == CNT_W'(MAX_POINTS));
  assign emit_ok     = !out_valid || out_ready;
  assign clear_lists = (state == S_EMIT) && emit_ok;

  mcma_dp_engine #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .ld_valid     (accept),
    .ld_is_source (is_source),
    .ld_point     ({row, col}),
    .clear_lists  (clear_lists),
    .start        (start),
    .target_count (target_count),
    .source_count (source_count),
    .status       (status)
  );

  // control sequence and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      out_valid     <= 1'b0;
      overflow_seen <= 1'b0;
      start         <= 1'b0;
    end else begin
      if (out_valid && out_ready && !clear_lists) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (drop) begin
              overflow_seen <= 1'b1;
            end
            if (last) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          priority if (target_count == '0) begin
            res_dist <= '0;
            res_inf  <= 1'b0;
            state    <= S_EMIT;
          end else if (target_count > source_count) begin
            res_dist <= '0;
            res_inf  <= 1'b1;
            state    <= S_EMIT;
          end else begin
            start <= 1'b1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          start <= 1'b0;
          if (status.done) begin
            res_dist <= (status.best > mcma_pkg::COST_CAP)
                      ? mcma_pkg::COST_CAP[mcma_pkg::DIST_OUT_W-1:0]
                      : status.best[mcma_pkg::DIST_OUT_W-1:0];
            res_inf  <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid      <= 1'b1;
            total_distance <= res_dist;
            infeasible     <= res_inf;
            overflow       <= overflow_seen;
            overflow_seen  <= 1'b0;
            state          <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

FILE: hdl/mcma_dp_engine.sv
// point lists, subset dp table and the sweep that fills it
`timescale 1ns / 1ps

module mcma_dp_engine #(
  parameter int MAX_POINTS = 15,
  parameter int COORD_BITS = 6
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    ld_valid,
  input  logic                                    ld_is_source,
  input  logic [2*COORD_BITS-1:0]                 ld_point,
  input  logic                                    clear_lists,
  input  logic                                    start,
  output logic [$clog2(MAX_POINTS+1)-1:0]         target_count,
  output logic [$clog2(MAX_POINTS+1)-1:0]         source_count,
  output mcma_pkg::dp_status_t                    status
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int MASK_W = MAX_POINTS;
  localparam int DEPTH  = 1 << MAX_POINTS;
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int DIST_W = COORD_BITS + 1;
  localparam int SUM_W  = mcma_pkg::COST_W + 1;

  typedef enum logic [2:0] {
    C_IDLE,
    C_CLEAR,
    C_BASE,
    C_UPD,
    C_DRAIN,
    C_DONE
  } cstate_t;

  cstate_t                 cstate;
  logic [PT_W-1:0]         target_points [MAX_POINTS];
  logic [PT_W-1:0]         source_points [MAX_POINTS];
  logic [MASK_W-1:0]       mask;
  logic [IDX_W-1:0]        si;
  logic [CNT_W-1:0]        ti;
  mcma_pkg::cost_t         best;
  mcma_pkg::cost_t         base;

  // dp table and its registered read port
  mcma_pkg::cost_t         subset_cost [DEPTH];
  mcma_pkg::cost_t         rd_data;
  logic [MASK_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [MASK_W-1:0]       wr_addr;
  mcma_pkg::cost_t         wr_data;

  // second stage of the read-modify-write pipe
  logic                    s1_valid;
  logic                    s1_base;
  logic [MASK_W-1:0]       s1_addr;
  logic [DIST_W-1:0]       s1_dist;

  // last dp write, for reads issued on the same edge
  logic                    fw_valid;
  logic [MASK_W-1:0]       fw_addr;
  mcma_pkg::cost_t         fw_data;

  logic [MASK_W-1:0]       last_mask;
  logic                    si_last;
  logic                    si_used;
  logic [MASK_W-1:0]       next_mask;
  logic [PT_W-1:0]         tp;
  logic [PT_W-1:0]         sp;
  logic [COORD_BITS-1:0]   dr;
  logic [COORD_BITS-1:0]   dc;
  logic [DIST_W-1:0]       pt_dist;
  logic                    issue_base;
  logic                    issue_upd;
  mcma_pkg::cost_t         cur;
  logic [SUM_W-1:0]        sum;
  mcma_pkg::cost_t         cand;
  logic                    live;
  logic                    upd_write;
  logic                    clearing;

  logic [CNT_W-1:0] tgt_cnt_q;
  logic [CNT_W-1:0] src_cnt_q;

  assign target_count = tgt_cnt_q;
  assign source_count = src_cnt_q;

  // point list loading
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_cnt_q <= '0;
      src_cnt_q <= '0;
    end else if (clear_lists) begin
      tgt_cnt_q <= '0;
      src_cnt_q <= '0;
    end else if (ld_valid) begin
      if (ld_is_source) begin
        if (src_cnt_q < CNT_W'(MAX_POINTS)) begin
          src_cnt_q <= src_cnt_q + CNT_W'(1);
        end
      end else begin
        if (tgt_cnt_q < CNT_W'(MAX_POINTS)) begin
          tgt_cnt_q <= tgt_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && !clear_lists) begin
      if (ld_is_source && (src_cnt_q < CNT_W'(MAX_POINTS))) begin
        source_points[src_cnt_q[IDX_W-1:0]] <= ld_point;
      end
      if (!ld_is_source && (tgt_cnt_q < CNT_W'(MAX_POINTS))) begin
        target_points[tgt_cnt_q[IDX_W-1:0]] <= ld_point;
      end
    end
  end

  // sweep bounds
  assign last_mask = ~({MASK_W{1'b1}} << src_cnt_q);
  assign si_last   = (CNT_W'(si) == (src_cnt_q - CNT_W'(1)));
  assign si_used   = mask[si];
  assign next_mask = mask | (MASK_W'(1) << si);

  // manhattan distance of current target and source
  assign tp   = target_points[ti[IDX_W-1:0]];
  assign sp   = source_points[si];
  assign dr   = (tp[PT_W-1:COORD_BITS] > sp[PT_W-1:COORD_BITS])
              ? tp[PT_W-1:COORD_BITS] - sp[PT_W-1:COORD_BITS]
              : sp[PT_W-1:COORD_BITS] - tp[PT_W-1:COORD_BITS];
  assign dc   = (tp[COORD_BITS-1:0] > sp[COORD_BITS-1:0])
              ? tp[COORD_BITS-1:0] - sp[COORD_BITS-1:0]
              : sp[COORD_BITS-1:0] - tp[COORD_BITS-1:0];
  assign pt_dist = DIST_W'(dr) + DIST_W'(dc);

  // read issue
  assign issue_base = (cstate == C_BASE);
  assign issue_upd  = (cstate == C_UPD) && !si_used;
  assign rd_addr    = issue_base ? mask : next_mask;

  // second stage: forwarded entry, candidate cost and write decision
  assign cur  = (fw_valid && (fw_addr == s1_addr)) ? fw_data : rd_data;
  assign sum  = SUM_W'(base) + SUM_W'(s1_dist);
  assign cand = (sum > SUM_W'(mcma_pkg::COST_CAP)) ? mcma_pkg::COST_CAP
                                                   : sum[mcma_pkg::COST_W-1:0];
  assign live = (base != mcma_pkg::COST_INF) && (ti < tgt_cnt_q);
  assign upd_write = s1_valid && !s1_base && live && (cand < cur);

  // write port: clearing sweep or dp update
  assign clearing = (cstate == C_CLEAR);
  assign wr_en    = clearing || upd_write;
  assign wr_addr  = clearing ? mask : s1_addr;
  assign wr_data  = clearing ? ((mask == '0) ? '0 : mcma_pkg::COST_INF) : cand;

  // dp table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      subset_cost[wr_addr] <= wr_data;
    end
    rd_data <= subset_cost[rd_addr];
  end

  // pipe and forwarding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      s1_valid <= issue_base || issue_upd;
      fw_valid <= upd_write;
    end
    s1_base <= issue_base;
    s1_addr <= rd_addr;
    s1_dist <= pt_dist;
    fw_addr <= s1_addr;
    fw_data <= cand;
  end

  // base capture and running minimum over full-size subsets
  always_ff @(posedge clk) begin
    if (cstate == C_IDLE && start) begin
      best <= mcma_pkg::COST_INF;
    end else if (s1_valid && s1_base) begin
      base <= cur;
      if ((ti == tgt_cnt_q) && (cur < best)) begin
        best <= cur;
      end
    end
  end

  // sweep sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
    end else begin
      unique case (cstate)
        C_IDLE: begin
          if (start) begin
            mask   <= '0;
            cstate <= C_CLEAR;
          end
        end
        C_CLEAR: begin
          if (mask == last_mask) begin
            mask   <= '0;
            cstate <= C_BASE;
          end else begin
            mask <= mask + MASK_W'(1);
          end
        end
        C_BASE: begin
          ti     <= CNT_W'($countones(mask));
          si     <= '0;
          cstate <= C_UPD;
        end
        C_UPD: begin
          if (si_last) begin
            if (mask == last_mask) begin
              cstate <= C_DRAIN;
            end else begin
              mask   <= mask + MASK_W'(1);
              cstate <= C_BASE;
            end
          end else begin
            si <= si + IDX_W'(1);
          end
        end
        C_DRAIN: begin
          cstate <= C_DONE;
        end
        C_DONE: begin
          cstate <= C_IDLE;
        end
        default: begin
          cstate <= C_IDLE;
        end
      endcase
    end
  end

  assign status.done = (cstate == C_DONE);
  assign status.best = best;

endmodule

FILE: verif/tb.sv
// testbench for the min-cost manhattan assignment block: stimulus, prediction and checking
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PTS = 15;
  localparam int COORD_W = 6;
  localparam int OUT_W = mcma_pkg::DIST_OUT_W;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int UNREACHED = 32'h3FFF_FFFF;
  localparam int DIST_CEIL = 2047;

  // list selector carried by is_source
  localparam logic TO_TARGET = 1'b0;
  localparam logic TO_SOURCE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [OUT_W-1:0] total;
    logic             infeasible;
    logic             overflow;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic is_source = 1'b0;
  logic [COORD_W-1:0] row = '0;
  logic [COORD_W-1:0] col = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] total_distance;
  logic infeasible;
  logic overflow;

  // points waiting to be driven and results still owed by the block
  point_t  load_q[$];
  answer_t answer_q[$];
  int queued = 0;
  int accepted = 0;
  int results_seen = 0;
  int bad_results = 0;
  int cycles = 0;

  // predictor state: both point lists, their fill levels and the drop mark
  logic [COORD_W-1:0] tgt_row[MAX_PTS];
  logic [COORD_W-1:0] tgt_col[MAX_PTS];
  logic [COORD_W-1:0] src_row[MAX_PTS];
  logic [COORD_W-1:0] src_col[MAX_PTS];
  int tgt_cnt = 0;
  int src_cnt = 0;
  logic drop_seen = 1'b0;
  int unsigned cost_tab[0:(1 << MAX_PTS) - 1];

  // receiver hold-off
  int hold_left = 0;
  logic held = 1'b0;
  logic steady;

  min_cost_manhattan_assignment_top #(
    .MAX_POINTS(MAX_PTS),
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .is_source(is_source),
    .row(row),
    .col(col),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .total_distance(total_distance),
    .infeasible(infeasible),
    .overflow(overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // a stretch of transactions with no idling on either side
  assign steady = (accepted >= 150) && (accepted < 260);

  function automatic int gap(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // least summed distance over source subsets, target t extending subsets of t sources
  function automatic int best_assignment();
    int unsigned span;
    int unsigned mask;
    int unsigned grown;
    int unsigned c;
    int unsigned best;
    int ti;
    int si;
    span = 1 << src_cnt;
    best = UNREACHED;
    if (tgt_cnt == 0) return 0;
    for (mask = 0; mask < span; mask++) cost_tab[mask] = UNREACHED;
    cost_tab[0] = 0;
    for (mask = 0; mask < span; mask++) begin
      ti = $countones(mask);
      if (cost_tab[mask] < UNREACHED && ti < tgt_cnt) begin
        for (si = 0; si < src_cnt; si++) begin
          if (!mask[si]) begin
            grown = mask | (1 << si);
            c = cost_tab[mask] + gap(tgt_row[ti], src_row[si])
                + gap(tgt_col[ti], src_col[si]);
            if (c < cost_tab[grown]) cost_tab[grown] = c;
          end
        end
      end
    end
    for (mask = 0; mask < span; mask++)
      if ($countones(mask) == tgt_cnt && cost_tab[mask] < best) best = cost_tab[mask];
    return (best > DIST_CEIL) ? DIST_CEIL : int'(best);
  endfunction

  // store one accepted point and, on the final one, queue the expected answer
  function automatic void take_point(input point_t p);
    answer_t a;
    if (p.kind == TO_SOURCE) begin
      if (src_cnt < MAX_PTS) begin
        src_row[src_cnt] = p.row;
        src_col[src_cnt] = p.col;
        src_cnt++;
      end else begin
        drop_seen = 1'b1;
      end
    end else begin
      if (tgt_cnt < MAX_PTS) begin
        tgt_row[tgt_cnt] = p.row;
        tgt_col[tgt_cnt] = p.col;
        tgt_cnt++;
      end else begin
        drop_seen = 1'b1;
      end
    end
    if (p.last) begin
      a.infeasible = (tgt_cnt > src_cnt);
      a.total = a.infeasible ? '0 : OUT_W'(best_assignment());
      a.overflow = drop_seen;
      answer_q = {answer_q, a};
      tgt_cnt = 0;
      src_cnt = 0;
      drop_seen = 1'b0;
    end
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return COORD_W'($urandom);
  endfunction

  task automatic add_point(input logic kind, input int r, input int c, input logic fin);
    point_t p;
    p.kind = kind;
    p.row = COORD_W'(r);
    p.col = COORD_W'(c);
    p.last = fin;
    load_q = {load_q, p};
    queued++;
  endtask

  // one list of nt targets and ns sources in random order, closed by last
  task automatic add_list(input int nt, input int ns);
    int rt;
    int rs;
    logic kind;
    rt = nt;
    rs = ns;
    while (rt + rs > 0) begin
      kind = ($urandom_range(rt + rs - 1) < rs) ? TO_SOURCE : TO_TARGET;
      if (kind == TO_SOURCE) rs--;
      else rt--;
      add_point(kind, pick_coord(), pick_coord(), rt + rs == 0);
    end
  endtask

  // mostly small feasible lists, with infeasible, empty and overflowing ones mixed in
  task automatic add_random_list();
    int pick;
    int ns;
    int nt;
    pick = $urandom_range(99);
    if (pick < 68) begin
      ns = $urandom_range(1, 6);
      nt = $urandom_range(1, ns);
    end else if (pick < 80) begin
      ns = $urandom_range(0, 4);
      nt = ns + $urandom_range(1, 3);
    end else if (pick < 88) begin
      nt = 0;
      ns = $urandom_range(1, 5);
    end else if (pick < 94) begin
      ns = $urandom_range(7, 10);
      nt = $urandom_range(1, ns);
    end else if (pick < 97) begin
      ns = $urandom_range(0, 5);
      nt = MAX_PTS + $urandom_range(1, 2);
    end else begin
      nt = 0;
      ns = MAX_PTS + $urandom_range(1, 2);
    end
    add_list(nt, ns);
  endtask

  task automatic wait_drained();
    while (load_q.size() != 0 || accepted != queued || answer_q.size() != 0) @(negedge clk);
  endtask

  // driver: next point when the line is free, idling at random
  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (load_q.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
        p = load_q.pop_front();
        in_valid <= 1'b1;
        is_source <= p.kind;
        row <= p.row;
        col <= p.col;
        last <= p.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held && results_seen == 20) begin
      held <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // monitor: check each result transaction, then predict from each input transaction
  always @(posedge clk) begin
    answer_t want;
    point_t p;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (answer_q.size() == 0) begin
          if (bad_results < 10)
            $display("unexpected result: total=%0d infeasible=%0b overflow=%0b",
                     total_distance, infeasible, overflow);
          bad_results++;
        end else begin
          want = answer_q.pop_front();
          if (total_distance !== want.total || infeasible !== want.infeasible ||
              overflow !== want.overflow) begin
            if (bad_results < 10)
              $display({"mismatch: expected total=%0d inf=%0b ovf=%0b, ",
                        "got total=%0d inf=%0b ovf=%0b"},
                       want.total, want.infeasible, want.overflow,
                       total_distance, infeasible, overflow);
            bad_results++;
          end
        end
      end
      if (in_valid && in_ready) begin
        accepted <= accepted + 1;
        p.kind = is_source;
        p.row = row;
        p.col = col;
        p.last = last;
        take_point(p);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty target list, no sources, coordinate extremes, mixed order
    add_point(TO_SOURCE, 0, 0, 1'b1);
    add_point(TO_TARGET, 63, 63, 1'b1);
    add_point(TO_TARGET, 0, 63, 1'b0);
    add_point(TO_SOURCE, 63, 0, 1'b1);
    add_point(TO_SOURCE, 63, 63, 1'b0);
    add_point(TO_TARGET, 63, 63, 1'b1);
    add_point(TO_TARGET, 10, 10, 1'b0);
    add_point(TO_SOURCE, 1, 1, 1'b0);
    add_point(TO_SOURCE, 30, 30, 1'b0);
    add_point(TO_TARGET, 0, 0, 1'b1);
    add_point(TO_TARGET, 5, 40, 1'b0);
    add_point(TO_TARGET, 7, 0, 1'b0);
    add_point(TO_SOURCE, 0, 41, 1'b0);
    add_point(TO_SOURCE, 6, 2, 1'b0);
    add_point(TO_SOURCE, 63, 0, 1'b1);
    add_point(TO_SOURCE, 42, 21, 1'b0);
    add_point(TO_SOURCE, 21, 42, 1'b0);
    add_point(TO_TARGET, 42, 42, 1'b0);
    add_point(TO_TARGET, 21, 21, 1'b0);
    add_point(TO_TARGET, 0, 0, 1'b1);
    wait_drained();

    // random lists, then one list at full capacity with a dropped source
    while (queued < 200) add_random_list();
    add_list(MAX_PTS, MAX_PTS + 1);
    wait_drained();

    k = queued;
    while (queued < k + 200) add_random_list();
    wait_drained();

    repeat (50) @(negedge clk);
    if (answer_q.size() != 0)
      $display("%0d expected results never arrived", answer_q.size());
    if (bad_results == 0 && answer_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mcma_pkg.sv
hdl/mcma_dp_engine.sv
hdl/min_cost_manhattan_assignment_top.sv
verif/tb.sv
